FILE: hdl/idw_pkg.sv
// ============================================================================
// idw_pkg: shared types and constants for the IDW interpolator
// Node record, command codes, sequencer states and divider control bundles.
// ============================================================================
package idw_pkg;

    localparam int MAX_NODES_DEF = 64;   // default node store depth
    localparam int POS_W         = 16;   // position field width
    localparam int SMP_W         = 16;   // sample field width
    localparam int CMD_W         = 2;
    localparam int D2_W          = 34;   // squared distance width
    localparam int W_W           = 33;   // weight width (up to 2^32)
    localparam int MUL_A_W       = 34;   // multiplier operand a
    localparam int MUL_B_W       = 17;   // multiplier operand b
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int RECIP_STEPS   = 33;   // quotient bits of 2^32 / d2
    localparam int RES_W         = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [SMP_W-1:0] sample;
    } t_node;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MULX,
        S_MULY,
        S_DIST,
        S_RECIP,
        S_MULW,
        S_ACCUM,
        S_WRAP,
        S_FDIV,
        S_FINISH
    } t_state;

    // divider start request: recip selects 2^32 / divisor, else dividend / divisor
    typedef struct packed {
        logic start;
        logic recip;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;   // high in the cycle of the last step
    } t_div_rsp;

endpackage

FILE: hdl/idw_node_mem.sv
// ============================================================================
// idw_node_mem: node store
// One write port, one read port with registered read data.
// ============================================================================
module idw_node_mem
    import idw_pkg::*;
#(
    parameter int DEPTH = MAX_NODES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_node         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_node         o_rdata
);

    t_node r_mem [DEPTH];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/idw_divider.sv
// ============================================================================
// idw_divider: shared restoring divider
// One quotient bit per cycle. Serves both the per-node reciprocal
// 2^32 / d2 and the final num / den.
// ============================================================================
module idw_divider
    import idw_pkg::*;
#(
    parameter int NW = 57,                 // dividend / quotient width
    parameter int DW = 40,                 // divisor width
    parameter int SW = $clog2(NW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_req      i_req,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output t_div_rsp      o_rsp,
    output logic [NW-1:0] o_quotient
);

    logic [SW-1:0] r_cnt,  n_cnt;
    logic [DW-1:0] r_rem,  n_rem;
    logic [DW-1:0] r_dvs,  n_dvs;
    logic [NW-1:0] r_quo,  n_quo;

    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW:0]   w_diff;

    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_dvs = r_dvs;
        n_quo = r_quo;
        if (i_req.start) begin
            n_rem = '0;
            n_dvs = i_divisor;
            if (i_req.recip) begin
                n_quo = {1'b1, {(NW-1){1'b0}}};
                n_cnt = SW'(RECIP_STEPS);
            end else begin
                n_quo = i_dividend;
                n_cnt = SW'(NW);
            end
        end else if (r_cnt != '0) begin
            n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_quo = {r_quo[NW-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = (r_cnt == SW'(1));
    assign o_quotient = r_quo;

endmodule

FILE: hdl/idw_interpolator_core.sv
// ============================================================================
// idw_interpolator_core: inverse-distance-weighting interpolator, power 2
// Loads scattered nodes and answers point queries with a weighted mean.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_ready) carries a command and its fields.
//   Clear and load complete in the transfer cycle and give no result; a
//   load into a full store is dropped. A query gives exactly one result
//   on the output channel (o_valid / i_ready).
//   A query walks the stored nodes in load order; per node: store read,
//   dx^2 and dy^2 on the shared multiplier, the reciprocal 2^32 / d2 on
//   the shared divider, then weight times sample. When den is not zero,
//   a final num / den pass on the same divider follows, after which the
//   finished quotient is picked up. An exact hit ends the walk early.
//   One item is in work at a time: o_ready is high only when idle. The
//   result sits in an output register, so the next item can be taken
//   while a result waits for i_ready; a later result holds until the
//   earlier one is taken.
//   Reset empties the store (count to zero) and drops any pending result.
// ============================================================================
module idw_interpolator_core
    import idw_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [SMP_W-1:0] i_sample_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [RES_W-1:0] o_interpolated_value,
    output logic                    o_exact_hit
);

    localparam int LOGN = $clog2(MAX_NODES);
    localparam int AW   = (MAX_NODES > 1) ? LOGN : 1;
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int NUMW = PROD_W + LOGN;   // signed sum of weight * sample
    localparam int DENW = D2_W + LOGN;     // sum of weights, also holds d2

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state                   r_state, n_state;
    logic [CW-1:0]            r_cnt,   n_cnt;
    logic [CW-1:0]            r_idx,   n_idx;
    logic signed [POS_W-1:0]  r_qx,    n_qx;
    logic signed [POS_W-1:0]  r_qy,    n_qy;
    logic [D2_W-1:0]          r_d2,    n_d2;
    logic signed [NUMW-1:0]   r_num,   n_num;
    logic [DENW-1:0]          r_den,   n_den;
    logic                     r_neg,   n_neg;
    logic [RES_W-1:0]         r_res,   n_res;
    logic                     r_hit,   n_hit;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_ovalid, n_ovalid;
    logic [RES_W-1:0]         r_oval,   n_oval;
    logic                     r_ohit,   n_ohit;

    logic                     w_in_xfer;
    logic                     w_out_xfer;
    logic                     w_we;
    t_node                    w_wnode;
    t_node                    w_rd;

    // shared multiplier
    logic signed [MUL_B_W-1:0] w_dx;
    logic signed [MUL_B_W-1:0] w_dy;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic [D2_W-1:0]           w_d2_sum;

    // shared divider
    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;
    logic [NUMW-1:0]           w_mag;
    logic [NUMW-1:0]           w_quo;
    logic [DENW-1:0]           w_divisor;
    logic [RES_W:0]            w_q17;
    logic [RES_W:0]            w_q17_neg;
    logic [CW-1:0]             w_idx_nx;

    assign o_ready    = (r_state == S_IDLE);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = r_ovalid && i_ready;

    // ------------------------------------------------------------------
    // Node store
    // ------------------------------------------------------------------
    assign w_wnode.x      = i_pos_x;
    assign w_wnode.y      = i_pos_y;
    assign w_wnode.sample = i_sample_value;
    assign w_we = w_in_xfer && (i_cmd == CMD_LOAD) && (r_cnt < CW'(MAX_NODES));

    idw_node_mem #(
        .DEPTH (MAX_NODES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_wnode),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rd)
    );

    // ------------------------------------------------------------------
    // Multiplier: dx*dx, dy*dy, then weight*sample after the reciprocal, one per cycle
    // ------------------------------------------------------------------
    assign w_dx = {w_rd.x[POS_W-1], w_rd.x} - {r_qx[POS_W-1], r_qx};
    assign w_dy = {w_rd.y[POS_W-1], w_rd.y} - {r_qy[POS_W-1], r_qy};

    always_comb begin
        case (r_state)
            S_MULY: begin
                w_mul_a = MUL_A_W'(w_dy);
                w_mul_b = w_dy;
            end
            S_MULW: begin
                w_mul_a = {1'b0, w_quo[W_W-1:0]};
                w_mul_b = MUL_B_W'(w_rd.sample);
            end
            default: begin
                w_mul_a = MUL_A_W'(w_dx);
                w_mul_b = w_dx;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // dx^2 sits in r_d2, dy^2 in r_prod when in S_DIST
    assign w_d2_sum = r_d2 + r_prod[D2_W-1:0];

    // ------------------------------------------------------------------
    // Divider: reciprocal per node, final |num| / den once
    // ------------------------------------------------------------------
    assign w_mag     = r_num[NUMW-1] ? NUMW'(-r_num) : NUMW'(r_num);
    assign w_divisor = (r_state == S_DIST) ? DENW'(w_d2_sum) : r_den;

    idw_divider #(
        .NW (NUMW),
        .DW (DENW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_mag),
        .i_divisor  (w_divisor),
        .o_rsp      (w_div_rsp),
        .o_quotient (w_quo)
    );

    // quotient magnitude is at most 2^15, so 17 bits cover it with sign
    assign w_q17     = w_quo[RES_W:0];
    assign w_q17_neg = -w_q17;
    assign w_idx_nx  = r_idx + 1'b1;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_qx      = r_qx;
        n_qy      = r_qy;
        n_d2      = r_d2;
        n_num     = r_num;
        n_den     = r_den;
        n_neg     = r_neg;
        n_res     = r_res;
        n_hit     = r_hit;
        n_ovalid  = r_ovalid;
        n_oval    = r_oval;
        n_ohit    = r_ohit;
        w_div_req = '0;

        if (w_out_xfer) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    case (i_cmd)
                        CMD_CLEAR: begin
                            n_cnt = '0;
                        end
                        CMD_LOAD: begin
                            if (w_we) begin
                                n_cnt = r_cnt + 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            n_qx  = i_pos_x;
                            n_qy  = i_pos_y;
                            n_idx = '0;
                            n_num = '0;
                            n_den = '0;
                            n_hit = 1'b0;
                            // empty store: den stays 0, wrap gives 0
                            n_state = (r_cnt == '0) ? S_WRAP : S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_MULX;
            end
            S_MULX: begin
                n_state = S_MULY;
            end
            S_MULY: begin
                n_d2    = r_prod[D2_W-1:0];
                n_state = S_DIST;
            end
            S_DIST: begin
                if (w_d2_sum == '0) begin
                    // exact hit: earliest node at the query point wins
                    n_res   = w_rd.sample;
                    n_hit   = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    w_div_req.start = 1'b1;
                    w_div_req.recip = 1'b1;
                    n_state         = S_RECIP;
                end
            end
            S_RECIP: begin
                if (w_div_rsp.done) begin
                    n_state = S_MULW;
                end
            end
            S_MULW: begin
                n_state = S_ACCUM;
            end
            S_ACCUM: begin
                n_num = r_num + NUMW'(r_prod);
                n_den = r_den + DENW'(w_quo[W_W-1:0]);
                n_idx = w_idx_nx;
                n_state = (w_idx_nx == r_cnt) ? S_WRAP : S_READ;
            end
            S_WRAP: begin
                if (r_den == '0) begin
                    n_res   = '0;
                    n_state = S_FINISH;
                end else begin
                    n_neg           = r_num[NUMW-1];
                    w_div_req.start = 1'b1;
                    w_div_req.recip = 1'b0;
                    n_state         = S_FDIV;
                end
            end
            S_FDIV: begin
                // divider idle again: quotient holds all bits
                if (!w_div_rsp.busy) begin
                    n_res   = r_neg ? w_q17_neg[RES_W-1:0] : w_q17[RES_W-1:0];
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hand over once the output register is free
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oval   = r_res;
                    n_ohit   = r_hit;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_qx       <= n_qx;
        r_qy       <= n_qy;
        r_d2       <= n_d2;
        r_num      <= n_num;
        r_den      <= n_den;
        r_neg      <= n_neg;
        r_res      <= n_res;
        r_hit      <= n_hit;
        r_oval     <= n_oval;
        r_ohit     <= n_ohit;
    end

    assign o_valid              = r_ovalid;
    assign o_interpolated_value = r_oval;
    assign o_exact_hit          = r_ohit;

`ifndef NO_ASSERTIONS
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_rsp.busy)
        else $error("divider busy while sequencer idle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_NODES))
        else $error("node count beyond store depth");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_idx < r_cnt))
        else $error("node walk past loaded count");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_FINISH))
        else $error("result raised outside finish step");
`endif

endmodule

FILE: sim/testbench.sv
// ============================================================================
// testbench: self-checking bench for idw_interpolator_core
// Sends clear, load, query and unused commands with random sender gaps and
// receiver stalls. A shadow node store predicts every query result, and each
// result transfer is checked in order against the oldest prediction.
// ============================================================================
module testbench;
    import idw_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [POS_W-1:0] VAL_MIN = 16'sh8000;
    localparam logic signed [POS_W-1:0] VAL_MAX = 16'sh7FFF;

    // Worst case: ~270 items, each a full-store query, plus sender gaps
    // and receiver stalls, taken several times over.
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 3000;     // longer than a full-store query
    localparam int MAX_REPORTS  = 10;

    localparam longint TWO_POW_32 = 64'sd4294967296;

    // receiver stall patterns
    localparam int RX_STREAM = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_SPARSE = 2;

    typedef struct packed {
        logic signed [RES_W-1:0] value;
        logic                    hit;
    } t_idw_result;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    o_ready;
    logic [CMD_W-1:0]        i_cmd          = CMD_CLEAR;
    logic signed [POS_W-1:0] i_pos_x        = '0;
    logic signed [POS_W-1:0] i_pos_y        = '0;
    logic signed [SMP_W-1:0] i_sample_value = '0;
    logic                    o_valid;
    logic                    i_ready        = 1'b1;
    logic signed [RES_W-1:0] o_interpolated_value;
    logic                    o_exact_hit;

    idw_interpolator_core u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_cmd                (i_cmd),
        .i_pos_x              (i_pos_x),
        .i_pos_y              (i_pos_y),
        .i_sample_value       (i_sample_value),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_interpolated_value (o_interpolated_value),
        .o_exact_hit          (o_exact_hit)
    );

    // shadow copy of the node store
    logic signed [POS_W-1:0] node_x_shadow   [MAX_NODES_DEF];
    logic signed [POS_W-1:0] node_y_shadow   [MAX_NODES_DEF];
    logic signed [SMP_W-1:0] node_smp_shadow [MAX_NODES_DEF];
    int                      node_count_shadow = 0;

    t_idw_result pending_results[$];

    int error_count  = 0;
    int cycle_count  = 0;
    int useful_items = 0;   // transfers that change state or give a result
    int burst_left   = 0;

    int         rx_mode      = RX_STREAM;
    int         rx_mode_left = 0;
    logic [2:0] rx_phase     = '0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic signed [POS_W-1:0] rand16();
        return POS_W'($urandom());
    endfunction

    // extremes show up often so the accumulators see full-scale products
    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            default: return rand16();
        endcase
    endfunction

    // point within r of c; r of 32767 or more means anywhere
    function automatic logic signed [POS_W-1:0] near(int c, int r);
        int v;
        if (r >= 32767) return rand16();
        v = c + int'($urandom_range(0, 2 * r)) - r;
        return POS_W'(v);
    endfunction

    // Power-2 inverse-distance mean over the shadow store. First node at
    // the exact point wins; weight is floor(2^32 / d2), 0 when no weight.
    function automatic t_idw_result weighted_mean_at(logic signed [POS_W-1:0] qx,
                                                     logic signed [POS_W-1:0] qy);
        longint      num;
        longint      den;
        longint      dx;
        longint      dy;
        longint      d2;
        longint      w;
        longint      quo;
        int          k;
        t_idw_result r;
        num     = 0;
        den     = 0;
        r.value = '0;
        r.hit   = 1'b0;
        k       = 0;
        while (k < node_count_shadow && !r.hit) begin
            dx = longint'(node_x_shadow[k]) - longint'(qx);
            dy = longint'(node_y_shadow[k]) - longint'(qy);
            d2 = dx * dx + dy * dy;
            if (d2 == 0) begin
                r.value = node_smp_shadow[k];
                r.hit   = 1'b1;
            end else begin
                w   = TWO_POW_32 / d2;
                num = num + w * longint'(node_smp_shadow[k]);
                den = den + w;
            end
            k++;
        end
        if (!r.hit && den > 0) begin
            quo     = num / den;    // truncates toward zero
            r.value = quo[RES_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one transfer, then maybe a gap at the end of a burst
    // ------------------------------------------------------------------------
    task automatic push_command(input logic [CMD_W-1:0]        cmd,
                                input logic signed [POS_W-1:0] px,
                                input logic signed [POS_W-1:0] py,
                                input logic signed [SMP_W-1:0] smp);
        int gap;
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_pos_x        <= px;
        i_pos_y        <= py;
        i_sample_value <= smp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        case (cmd)
            CMD_CLEAR: begin
                node_count_shadow = 0;
                useful_items++;
            end
            CMD_LOAD: begin
                if (node_count_shadow < MAX_NODES_DEF) begin
                    node_x_shadow[node_count_shadow]   = px;
                    node_y_shadow[node_count_shadow]   = py;
                    node_smp_shadow[node_count_shadow] = smp;
                    node_count_shadow++;
                    useful_items++;
                end
            end
            CMD_QUERY: begin
                pending_results.push_back(weighted_mean_at(px, py));
                useful_items++;
            end
            default: ;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_empty_store();
        push_command(CMD_QUERY, 16'sd0, 16'sd0, 16'sd0);
        push_command(CMD_UNUSED, rand16(), rand16(), rand16());
        push_command(CMD_UNUSED, -16'sd1, -16'sd1, -16'sd1);
        push_command(CMD_QUERY, VAL_MIN, VAL_MAX, VAL_MIN);
    endtask

    task automatic test_extreme_nodes();
        push_command(CMD_LOAD, VAL_MIN, VAL_MIN, VAL_MAX);
        push_command(CMD_LOAD, VAL_MAX, VAL_MAX, VAL_MIN);
        push_command(CMD_QUERY, 16'sd0, 16'sd0, 16'sd0);
        push_command(CMD_QUERY, 16'sd100, -16'sd200, 16'sd0);
        push_command(CMD_QUERY, VAL_MIN, VAL_MIN, 16'sd0);
        // duplicate position: earliest load must still win
        push_command(CMD_LOAD, VAL_MIN, VAL_MIN, -16'sd5);
        push_command(CMD_QUERY, VAL_MIN, VAL_MIN, VAL_MAX);
        push_command(CMD_QUERY, VAL_MAX, VAL_MAX, 16'sd0);
    endtask

    // d2 above 2^32 gives weight 0; just below gives weight 1
    task automatic test_far_nodes();
        push_command(CMD_CLEAR, rand16(), rand16(), rand16());
        push_command(CMD_LOAD, VAL_MIN, VAL_MIN, 16'sd1000);
        push_command(CMD_QUERY, VAL_MAX, VAL_MAX, 16'sd0);
        push_command(CMD_QUERY, VAL_MAX, VAL_MIN, 16'sd0);
        push_command(CMD_QUERY, VAL_MAX, -16'sd32000, 16'sd0);
    endtask

    // clear drops the count only; old entries must not be seen
    task automatic test_clear_and_reload();
        push_command(CMD_CLEAR, rand16(), rand16(), rand16());
        push_command(CMD_QUERY, VAL_MIN, VAL_MIN, 16'sd0);
        push_command(CMD_LOAD, 16'sd0, 16'sd0, -16'sd1);
        push_command(CMD_QUERY, 16'sd1, 16'sd1, 16'sd0);
        push_command(CMD_QUERY, 16'sd0, 16'sd0, 16'sd0);
    endtask

    // ------------------------------------------------------------------------
    // Random tests
    // ------------------------------------------------------------------------
    // Scenes: clear, a handful of nodes around a center, then queries that
    // hit nodes, land nearby or land anywhere. Some scenes skip the clear,
    // some have no nodes, and unused commands are mixed in as noise.
    task automatic test_random_scenes(input int target);
        int                      first;
        int                      n_nodes;
        int                      n_queries;
        int                      radius;
        int                      cx;
        int                      cy;
        int                      k;
        int                      idx;
        logic signed [POS_W-1:0] qx;
        logic signed [POS_W-1:0] qy;
        first = useful_items;
        while (useful_items - first < target) begin
            if ($urandom_range(0, 7) != 0 || node_count_shadow > 32) begin
                push_command(CMD_CLEAR, rand16(), rand16(), rand16());
            end
            case ($urandom_range(0, 9))
                0:       n_nodes = 0;
                1:       n_nodes = $urandom_range(9, 24);
                default: n_nodes = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 3))
                0:       radius = 2;
                1:       radius = 40;
                2:       radius = 1500;
                default: radius = 32767;
            endcase
            cx = int'($urandom_range(0, 60000)) - 30000;
            cy = int'($urandom_range(0, 60000)) - 30000;
            for (k = 0; k < n_nodes; k++) begin
                push_command(CMD_LOAD, near(cx, radius), near(cy, radius), pick_sample());
            end
            n_queries = $urandom_range(1, 5);
            for (k = 0; k < n_queries; k++) begin
                case ($urandom_range(0, 3))
                    0: begin
                        if (node_count_shadow > 0) begin
                            idx = $urandom_range(0, node_count_shadow - 1);
                            qx  = node_x_shadow[idx];
                            qy  = node_y_shadow[idx];
                        end else begin
                            qx = rand16();
                            qy = rand16();
                        end
                    end
                    3: begin
                        qx = rand16();
                        qy = rand16();
                    end
                    default: begin
                        qx = near(cx, radius);
                        qy = near(cy, radius);
                    end
                endcase
                push_command(CMD_QUERY, qx, qy, rand16());
            end
            if ($urandom_range(0, 5) == 0) begin
                push_command(CMD_UNUSED, rand16(), rand16(), rand16());
            end
        end
    endtask

    // Fill all entries, push a few more that must be dropped, query at a
    // dropped node, at the last stored node and nearby.
    task automatic test_full_store();
        int                      cx;
        int                      cy;
        int                      k;
        int                      extra;
        logic signed [POS_W-1:0] lx;
        logic signed [POS_W-1:0] ly;
        push_command(CMD_CLEAR, rand16(), rand16(), rand16());
        cx = int'($urandom_range(0, 60000)) - 30000;
        cy = int'($urandom_range(0, 60000)) - 30000;
        for (k = 0; k < MAX_NODES_DEF; k++) begin
            push_command(CMD_LOAD, near(cx, 300), near(cy, 300), pick_sample());
        end
        extra = $urandom_range(1, 4);
        lx    = '0;
        ly    = '0;
        for (k = 0; k < extra; k++) begin
            lx = near(cx, 300);
            ly = near(cy, 300);
            push_command(CMD_LOAD, lx, ly, pick_sample());
        end
        push_command(CMD_QUERY, lx, ly, rand16());
        push_command(CMD_QUERY, node_x_shadow[MAX_NODES_DEF-1],
                     node_y_shadow[MAX_NODES_DEF-1], rand16());
        push_command(CMD_QUERY, near(cx, 300), near(cy, 300), rand16());
        // pressure: nothing new until every query has answered
        hold_until_drained();
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall pattern: stream, random, or one ready in eight
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(RX_STREAM, RX_SPARSE);
            rx_mode_left <= $urandom_range(20, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        rx_phase <= rx_phase + 3'd1;
        case (rx_mode)
            RX_STREAM: i_ready <= 1'b1;
            RX_RANDOM: i_ready <= ($urandom_range(0, 3) != 0);
            default:   i_ready <= (rx_phase == 3'd0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Result check: each result transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_idw_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("unexpected result: value %0d hit %0b",
                             o_interpolated_value, o_exact_hit);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_interpolated_value !== want.value || o_exact_hit !== want.hit) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("result mismatch: value exp %0d got %0d, hit exp %0b got %0b",
                                 want.value, o_interpolated_value, want.hit, o_exact_hit);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_extreme_nodes();
        test_far_nodes();
        test_clear_and_reload();

        test_random_scenes(100);
        test_full_store();
        test_random_scenes(70);

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/idw_pkg.sv
hdl/idw_node_mem.sv
hdl/idw_divider.sv
hdl/idw_interpolator_core.sv
sim/testbench.sv
